>>> rtl/pdc_pkg.sv
// ----------------------------------------------------------------------------
// pdc_pkg
// shared types, codes and widths of the condensed pairwise distance block
// ----------------------------------------------------------------------------
package pdc_pkg;

  // default sizes
  localparam int DEF_MAX_ROWS      = 64;
  localparam int DEF_MAX_ELEMENTS  = 64;
  localparam int DEF_ELEMENT_WIDTH = 16;

  // field and register widths
  localparam int ROWF_W     = 6;
  localparam int PAIR_W     = 11;
  localparam int VAL_W      = 16;
  localparam int DIST_W     = 22;
  localparam int ACC_W      = 2 * DIST_W;
  localparam int CNTREG_W   = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  // commands
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // norm modes
  localparam logic [1:0] NORM_COUNT = 2'd0;
  localparam logic [1:0] NORM_L1    = 2'd1;
  localparam logic [1:0] NORM_L2    = 2'd2;
  localparam logic [1:0] NORM_MAX   = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NORM_MODE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ELEMENT_COUNT = 2'd2;

  // register reset values
  localparam logic [1:0]          NORM_RESET  = NORM_L2;
  localparam logic [CNTREG_W-1:0] ROWS_RESET  = 7'd0;
  localparam logic [CNTREG_W-1:0] ELEMS_RESET = 7'd1;

  typedef struct packed {
    logic                     command;
    logic [ROWF_W-1:0]        row;
    logic [ROWF_W-1:0]        column;
    logic signed [VAL_W-1:0]  element_value;
    logic [PAIR_W-1:0]        pair_index;
  } in_item_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic [ROWF_W-1:0] first_row;
    logic [ROWF_W-1:0] second_row;
    logic              index_error;
  } out_item_t;

  typedef struct packed {
    logic [1:0]          norm_mode;
    logic [CNTREG_W-1:0] row_count;
    logic [CNTREG_W-1:0] element_count;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_WALK,
    ST_DRAIN,
    ST_ROOT,
    ST_DONE
  } state_t;

endpackage

>>> rtl/pdc_store.sv
// ----------------------------------------------------------------------------
// pdc_store
// vector store: one write port, two read ports, registered read data
// ----------------------------------------------------------------------------
module pdc_store #(
  parameter int DEPTH  = pdc_pkg::DEF_MAX_ROWS * pdc_pkg::DEF_MAX_ELEMENTS,
  parameter int DATA_W = pdc_pkg::DEF_ELEMENT_WIDTH
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_W-1:0]        wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [DATA_W-1:0]        rdata_a,
  output logic [DATA_W-1:0]        rdata_b
);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [DATA_W-1:0] rdata_a_r;
  logic [DATA_W-1:0] rdata_b_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_a_r <= mem_r[raddr_a];
    rdata_b_r <= mem_r[raddr_b];
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

>>> rtl/pdc_isqrt.sv
// ----------------------------------------------------------------------------
// pdc_isqrt
// floor square root, two radicand bits per cycle, one root bit per cycle
// ----------------------------------------------------------------------------
module pdc_isqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [pdc_pkg::ACC_W-1:0]   radicand,
  output logic                        done,
  output logic [pdc_pkg::DIST_W-1:0]  root
);

  localparam int RW     = pdc_pkg::DIST_W;
  localparam int AW     = pdc_pkg::ACC_W;
  localparam int REM_W  = RW + 1;
  localparam int STEP_W = $clog2(RW);

  logic              run_r, run_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [AW-1:0]     val_r, val_nxt;
  logic [REM_W-1:0]  rem_r, rem_nxt;
  logic [RW-1:0]     root_r, root_nxt;

  logic [REM_W+1:0]  rem_sh;
  logic [REM_W+1:0]  trial;

  always_comb begin
    rem_sh   = {rem_r, val_r[AW-1:AW-2]};
    trial    = {1'b0, root_r, 2'b01};
    run_nxt  = run_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    val_nxt  = val_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    if (start) begin
      run_nxt  = 1'b1;
      step_nxt = '0;
      val_nxt  = radicand;
      rem_nxt  = '0;
      root_nxt = '0;
    end else if (run_r) begin
      val_nxt = {val_r[AW-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_nxt  = REM_W'(rem_sh - trial);
        root_nxt = {root_r[RW-2:0], 1'b1};
      end else begin
        rem_nxt  = REM_W'(rem_sh);
        root_nxt = {root_r[RW-2:0], 1'b0};
      end
      step_nxt = step_r + STEP_W'(1);
      if (step_r == STEP_W'(RW - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r  <= val_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign done = done_r;
  assign root = root_r;

endmodule

>>> rtl/pdc_core.sv
// ----------------------------------------------------------------------------
// pdc_core
// query sequencer: pair index search, element walk over the store, norm
// accumulation and final root
// ----------------------------------------------------------------------------
module pdc_core #(
  parameter int MAX_ROWS      = pdc_pkg::DEF_MAX_ROWS,
  parameter int MAX_ELEMENTS  = pdc_pkg::DEF_MAX_ELEMENTS,
  parameter int ELEMENT_WIDTH = pdc_pkg::DEF_ELEMENT_WIDTH
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  pdc_pkg::cfg_t                               cfg,
  input  logic                                        start,
  input  logic [pdc_pkg::PAIR_W-1:0]                  pair_index,
  output logic                                        idle,
  output logic [$clog2(MAX_ROWS*MAX_ELEMENTS)-1:0]    rd_addr_a,
  output logic [$clog2(MAX_ROWS*MAX_ELEMENTS)-1:0]    rd_addr_b,
  input  logic [ELEMENT_WIDTH-1:0]                    rd_data_a,
  input  logic [ELEMENT_WIDTH-1:0]                    rd_data_b,
  output logic                                        res_valid,
  input  logic                                        res_take,
  output pdc_pkg::out_item_t                          res
);

  localparam int DEPTH  = MAX_ROWS * MAX_ELEMENTS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(MAX_ELEMENTS + 1);
  localparam int EW     = ELEMENT_WIDTH;
  localparam int SQ_W   = 2 * EW;
  localparam int ACC_W  = pdc_pkg::ACC_W;
  localparam int SQX_W  = (SQ_W > ACC_W) ? SQ_W : ACC_W;
  localparam int DW     = pdc_pkg::DIST_W;
  localparam int RC_W   = pdc_pkg::CNTREG_W;
  localparam int BASE_W = 2 * RC_W - 1;
  localparam int PW     = pdc_pkg::PAIR_W;
  localparam int RF_W   = pdc_pkg::ROWF_W;
  localparam logic [ADDR_W-1:0] ELEMS_A = ADDR_W'(MAX_ELEMENTS);

  pdc_pkg::state_t state_r, state_nxt;

  logic [PW-1:0]     k_r, k_nxt;
  logic [RC_W-1:0]   i_r, i_nxt;
  logic [RC_W-1:0]   j_r, j_nxt;
  logic [BASE_W-1:0] base_r, base_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [2:0]        v_r, v_nxt;
  logic [ACC_W-1:0]  acc_r, acc_nxt;
  logic              ovf_r, ovf_nxt;
  logic              err_r, err_nxt;
  logic [DW-1:0]     dist_r, dist_nxt;

  logic [EW-1:0]     d_r, d2_r;
  logic [SQ_W-1:0]   sq_r;

  logic [RC_W-1:0]   n_eff;
  logic [CNT_W-1:0]  m_eff;
  logic              last_row;
  logic [RC_W-1:0]   len;
  logic [BASE_W-1:0] lim;
  logic              hit;
  logic [BASE_W-1:0] j_calc;
  logic [EW:0]       diff;
  logic [EW:0]       absd;
  logic [SQX_W-1:0]  sq_ext;
  logic              sq_big;
  logic [ACC_W-1:0]  term;
  logic [ACC_W-1:0]  d_ext;
  logic [ACC_W:0]    sum;
  logic              sqrt_start;
  logic              sqrt_done;
  logic [DW-1:0]     sqrt_root;

  // effective sizes, saturated at the store limits
  assign n_eff = (32'(cfg.row_count) > MAX_ROWS) ? RC_W'(MAX_ROWS) : cfg.row_count;
  assign m_eff = (32'(cfg.element_count) > MAX_ELEMENTS) ? CNT_W'(MAX_ELEMENTS)
                                                           : CNT_W'(cfg.element_count);

  // one row start per cycle
  assign last_row = ({1'b0, i_r} + 8'd1) >= {1'b0, n_eff};
  assign len      = n_eff - RC_W'(1) - i_r;
  assign lim      = base_r + BASE_W'(len);
  assign hit      = BASE_W'(k_r) < lim;
  assign j_calc   = BASE_W'(k_r) - base_r + BASE_W'(i_r) + BASE_W'(1);

  assign rd_addr_a = ADDR_W'(i_r) * ELEMS_A + ADDR_W'(cnt_r);
  assign rd_addr_b = ADDR_W'(j_r) * ELEMS_A + ADDR_W'(cnt_r);

  assign diff   = {rd_data_a[EW-1], rd_data_a} - {rd_data_b[EW-1], rd_data_b};
  assign absd   = diff[EW] ? (~diff + (EW+1)'(1)) : diff;
  assign sq_ext = SQX_W'(sq_r);
  assign sq_big = |(sq_ext >> ACC_W);
  assign d_ext  = ACC_W'(d2_r);

  always_comb begin
    case (cfg.norm_mode)
      pdc_pkg::NORM_COUNT: term = ACC_W'(d2_r != '0);
      pdc_pkg::NORM_L1:    term = d_ext;
      pdc_pkg::NORM_L2:    term = sq_ext[ACC_W-1:0];
      default:             term = '0;
    endcase
  end

  assign sum = {1'b0, acc_r} + {1'b0, term};

  always_comb begin
    state_nxt  = state_r;
    k_nxt      = k_r;
    i_nxt      = i_r;
    j_nxt      = j_r;
    base_nxt   = base_r;
    cnt_nxt    = cnt_r;
    v_nxt      = {v_r[1:0], 1'b0};
    acc_nxt    = acc_r;
    ovf_nxt    = ovf_r;
    err_nxt    = err_r;
    dist_nxt   = dist_r;
    sqrt_start = 1'b0;

    // accumulate stage
    if (v_r[2]) begin
      if (cfg.norm_mode == pdc_pkg::NORM_MAX) begin
        if (d_ext > acc_r) begin
          acc_nxt = d_ext;
        end
      end else begin
        acc_nxt = sum[ACC_W-1:0];
        ovf_nxt = ovf_r | sum[ACC_W] |
                  (sq_big & (cfg.norm_mode == pdc_pkg::NORM_L2));
      end
    end

    case (state_r)
      pdc_pkg::ST_IDLE: begin
        if (start) begin
          k_nxt     = pair_index;
          i_nxt     = '0;
          base_nxt  = '0;
          acc_nxt   = '0;
          ovf_nxt   = 1'b0;
          err_nxt   = 1'b0;
          dist_nxt  = '0;
          state_nxt = pdc_pkg::ST_SEARCH;
        end
      end
      pdc_pkg::ST_SEARCH: begin
        if (last_row) begin
          err_nxt   = 1'b1;
          dist_nxt  = '0;
          state_nxt = pdc_pkg::ST_DONE;
        end else if (hit) begin
          j_nxt     = j_calc[RC_W-1:0];
          cnt_nxt   = '0;
          state_nxt = (m_eff == '0) ? pdc_pkg::ST_DRAIN : pdc_pkg::ST_WALK;
        end else begin
          base_nxt = lim;
          i_nxt    = i_r + RC_W'(1);
        end
      end
      pdc_pkg::ST_WALK: begin
        v_nxt[0] = 1'b1;
        cnt_nxt  = cnt_r + CNT_W'(1);
        if (cnt_r + CNT_W'(1) == m_eff) begin
          state_nxt = pdc_pkg::ST_DRAIN;
        end
      end
      pdc_pkg::ST_DRAIN: begin
        if (v_r == 3'b000) begin
          if (cfg.norm_mode == pdc_pkg::NORM_L2) begin
            if (ovf_r) begin
              dist_nxt  = pdc_pkg::DIST_MAX;
              state_nxt = pdc_pkg::ST_DONE;
            end else begin
              sqrt_start = 1'b1;
              state_nxt  = pdc_pkg::ST_ROOT;
            end
          end else begin
            dist_nxt  = (ovf_r || (acc_r[ACC_W-1:DW] != '0)) ? pdc_pkg::DIST_MAX
                                                              : acc_r[DW-1:0];
            state_nxt = pdc_pkg::ST_DONE;
          end
        end
      end
      pdc_pkg::ST_ROOT: begin
        if (sqrt_done) begin
          dist_nxt  = sqrt_root;
          state_nxt = pdc_pkg::ST_DONE;
        end
      end
      pdc_pkg::ST_DONE: begin
        if (res_take) begin
          state_nxt = pdc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = pdc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pdc_pkg::ST_IDLE;
      v_r     <= 3'b000;
    end else begin
      state_r <= state_nxt;
      v_r     <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r    <= k_nxt;
    i_r    <= i_nxt;
    j_r    <= j_nxt;
    base_r <= base_nxt;
    cnt_r  <= cnt_nxt;
    acc_r  <= acc_nxt;
    ovf_r  <= ovf_nxt;
    err_r  <= err_nxt;
    dist_r <= dist_nxt;
    d_r    <= absd[EW-1:0];
    d2_r   <= d_r;
    sq_r   <= SQ_W'(d_r) * SQ_W'(d_r);
  end

  pdc_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sqrt_start),
    .radicand (acc_r),
    .done     (sqrt_done),
    .root     (sqrt_root)
  );

  assign idle      = (state_r == pdc_pkg::ST_IDLE);
  assign res_valid = (state_r == pdc_pkg::ST_DONE);

  always_comb begin
    res.distance    = err_r ? '0 : dist_r;
    res.first_row   = err_r ? '0 : i_r[RF_W-1:0];
    res.second_row  = err_r ? '0 : j_r[RF_W-1:0];
    res.index_error = err_r;
  end

endmodule

>>> rtl/pairwise_distance_condensed.sv
// ----------------------------------------------------------------------------
// pairwise_distance_condensed
// pairwise vector distance over a loaded store, condensed pair indexing
// ----------------------------------------------------------------------------
// Usage: in_valid/in_ready carries load and query commands, out_valid/out_ready
// carries one result per query. A load writes one element in the cycle of its
// transfer and gives no result. A query with condensed number k is mapped to
// rows i<j by a search over the row starts, one row per cycle, then the
// element_count elements of both rows are read from the store, one pair per
// cycle through its two read ports, into the difference, square and accumulate
// stages. Euclidean mode adds a bit-serial square root. One query is worked on
// at a time; no load or query is taken while a query is in progress.
// An index outside the condensed range gives index_error with zero fields.
// Reset sets norm_mode to Euclidean, row_count 0, element_count 1; store
// contents are undefined until loaded and reset does not clear them.
// The result register lets the next command transfer while a result waits;
// a finished query then holds until out_ready frees the register.
// Configuration is written through cfg_we/cfg_index/cfg_data while idle; the
// user must keep to this, as the block itself does not enforce it.
// ----------------------------------------------------------------------------
module pairwise_distance_condensed #(
  parameter int MAX_ROWS      = pdc_pkg::DEF_MAX_ROWS,
  parameter int MAX_ELEMENTS  = pdc_pkg::DEF_MAX_ELEMENTS,
  parameter int ELEMENT_WIDTH = pdc_pkg::DEF_ELEMENT_WIDTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  pdc_pkg::in_item_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output pdc_pkg::out_item_t                out_result,
  input  logic                              cfg_we,
  input  logic [pdc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pdc_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int DEPTH  = MAX_ROWS * MAX_ELEMENTS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam logic [ADDR_W-1:0] ELEMS_A = ADDR_W'(MAX_ELEMENTS);

  logic [1:0]                   norm_r;
  logic [pdc_pkg::CNTREG_W-1:0] rows_r;
  logic [pdc_pkg::CNTREG_W-1:0] elems_r;
  pdc_pkg::cfg_t                cfg;

  logic                         out_valid_r, out_valid_nxt;
  pdc_pkg::out_item_t           out_result_r;

  logic                         in_fire;
  logic                         core_idle;
  logic                         core_start;
  logic                         wr_en;
  logic [ADDR_W-1:0]            wr_addr;
  logic [ELEMENT_WIDTH-1:0]     wr_data;
  logic [ADDR_W-1:0]            rd_addr_a, rd_addr_b;
  logic [ELEMENT_WIDTH-1:0]     rd_data_a, rd_data_b;
  logic                         res_valid;
  logic                         res_take;
  pdc_pkg::out_item_t           res;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      norm_r  <= pdc_pkg::NORM_RESET;
      rows_r  <= pdc_pkg::ROWS_RESET;
      elems_r <= pdc_pkg::ELEMS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        pdc_pkg::REG_NORM_MODE:     norm_r  <= cfg_data[1:0];
        pdc_pkg::REG_ROW_COUNT:     rows_r  <= cfg_data;
        pdc_pkg::REG_ELEMENT_COUNT: elems_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg.norm_mode     = norm_r;
  assign cfg.row_count     = rows_r;
  assign cfg.element_count = elems_r;

  assign in_ready   = core_idle;
  assign in_fire    = in_valid & in_ready;
  assign core_start = in_fire & (in_data.command == pdc_pkg::CMD_QUERY);

  // element load, out-of-store writes dropped
  assign wr_en   = in_fire & (in_data.command == pdc_pkg::CMD_LOAD) &
                   (32'(in_data.row) < MAX_ROWS) & (32'(in_data.column) < MAX_ELEMENTS);
  assign wr_addr = ADDR_W'(in_data.row) * ELEMS_A + ADDR_W'(in_data.column);
  assign wr_data = ELEMENT_WIDTH'(in_data.element_value);

  pdc_store #(
    .DEPTH  (DEPTH),
    .DATA_W (ELEMENT_WIDTH)
  ) u_store (
    .clk     (clk),
    .we      (wr_en),
    .waddr   (wr_addr),
    .wdata   (wr_data),
    .raddr_a (rd_addr_a),
    .raddr_b (rd_addr_b),
    .rdata_a (rd_data_a),
    .rdata_b (rd_data_b)
  );

  pdc_core #(
    .MAX_ROWS      (MAX_ROWS),
    .MAX_ELEMENTS  (MAX_ELEMENTS),
    .ELEMENT_WIDTH (ELEMENT_WIDTH)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .start      (core_start),
    .pair_index (in_data.pair_index),
    .idle       (core_idle),
    .rd_addr_a  (rd_addr_a),
    .rd_addr_b  (rd_addr_b),
    .rd_data_a  (rd_data_a),
    .rd_data_b  (rd_data_b),
    .res_valid  (res_valid),
    .res_take   (res_take),
    .res        (res)
  );

  // result register
  assign res_take = res_valid & (~out_valid_r | out_ready);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_take) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_result_r <= res;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;

  // a query transfer starts the sequencer
  a_query_busy : assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && in_fire && in_data.command == pdc_pkg::CMD_QUERY) |=> !in_ready)
    else $error("query transfer did not start the sequencer");

  // a load never produces a result
  a_load_idle : assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && in_fire && in_data.command == pdc_pkg::CMD_LOAD) |=> in_ready && !res_valid)
    else $error("load transfer left the sequencer busy");

  // bad pair index gives zero fields
  a_err_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_result.index_error) |->
      (out_result.distance == '0 && out_result.first_row == '0 &&
       out_result.second_row == '0))
    else $error("index error with nonzero result fields");

  // row count write lands
  a_cfg_rows : assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && cfg_we && cfg_index == pdc_pkg::REG_ROW_COUNT) |=> rows_r == $past(cfg_data))
    else $error("row count write lost");

endmodule

>>> dv/pdc_checker.sv
// ----------------------------------------------------------------------------
// pdc_checker
// watches the command, result and register ports of the condensed pairwise
// distance block, keeps its own copy of the vector store and registers,
// predicts each query result and compares it field by field, in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pdc_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  pdc_pkg::in_item_t              in_data,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  pdc_pkg::out_item_t             out_result,
  input  logic                           cfg_we,
  input  logic [pdc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pdc_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             mismatches,
  output int                             pending,
  output int                             results_checked,
  output int                             flagged_results
);

  localparam int ROWS  = pdc_pkg::DEF_MAX_ROWS;
  localparam int ELEMS = pdc_pkg::DEF_MAX_ELEMENTS;

  logic signed [pdc_pkg::VAL_W-1:0] store_copy [ROWS*ELEMS];
  logic [1:0]                       norm_q;
  logic [pdc_pkg::CNTREG_W-1:0]     rows_q;
  logic [pdc_pkg::CNTREG_W-1:0]     elems_q;
  pdc_pkg::out_item_t               distance_queue [$];

  int fail_total  = 0;
  int outstanding = 0;
  int checked     = 0;
  int flagged     = 0;

  assign mismatches      = fail_total;
  assign pending         = outstanding;
  assign results_checked = checked;
  assign flagged_results = flagged;

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    fail_total++;
  endtask

  // floor square root by setting root bits from the top down
  function automatic longint unsigned floor_root(longint unsigned v);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= v) begin
        root = trial;
      end
    end
    return root;
  endfunction

  function automatic pdc_pkg::out_item_t predict_distance(
      logic [pdc_pkg::PAIR_W-1:0] pair);
    pdc_pkg::out_item_t res;
    int                 n;
    int                 m;
    int                 k;
    int                 base;
    int                 i;
    int                 j;
    int                 len;
    int                 a;
    int                 b;
    bit                 hit;
    longint unsigned    d;
    longint unsigned    acc;
    res  = '0;
    n    = (int'(rows_q) > ROWS) ? ROWS : int'(rows_q);
    m    = (int'(elems_q) > ELEMS) ? ELEMS : int'(elems_q);
    k    = int'(pair);
    base = 0;
    i    = 0;
    j    = 0;
    hit  = 0;
    while (!hit && i + 1 < n) begin
      len = n - 1 - i;
      if (k < base + len) begin
        j   = k - base + i + 1;
        hit = 1;
      end else begin
        base += len;
        i++;
      end
    end
    if (!hit) begin
      res.index_error = 1'b1;
      return res;
    end
    acc = 0;
    for (int c = 0; c < m; c++) begin
      a = int'(store_copy[i*ELEMS + c]);
      b = int'(store_copy[j*ELEMS + c]);
      d = longint'((a >= b) ? a - b : b - a);
      case (norm_q)
        pdc_pkg::NORM_COUNT: if (d != 0) acc++;
        pdc_pkg::NORM_L1:    acc += d;
        pdc_pkg::NORM_L2:    acc += d * d;
        default:             if (d > acc) acc = d;
      endcase
    end
    if (norm_q == pdc_pkg::NORM_L2) begin
      acc = floor_root(acc);
    end
    if (acc > 64'(pdc_pkg::DIST_MAX)) begin
      acc = 64'(pdc_pkg::DIST_MAX);
    end
    res.distance   = acc[pdc_pkg::DIST_W-1:0];
    res.first_row  = i[pdc_pkg::ROWF_W-1:0];
    res.second_row = j[pdc_pkg::ROWF_W-1:0];
    return res;
  endfunction

  always @(posedge clk) begin : watch
    pdc_pkg::out_item_t want;
    if (!rst_n) begin
      norm_q  <= pdc_pkg::NORM_RESET;
      rows_q  <= pdc_pkg::ROWS_RESET;
      elems_q <= pdc_pkg::ELEMS_RESET;
      distance_queue.delete();
      outstanding <= 0;
    end else begin
      // result transfer first, so a result never meets its own query
      if (out_valid && out_ready) begin
        if (distance_queue.size() == 0) begin
          report_mismatch("result with nothing outstanding",
                          32'(out_result.distance), 32'd0);
        end else begin
          want = distance_queue.pop_front();
          if (out_result.distance !== want.distance)
            report_mismatch("distance", 32'(out_result.distance), 32'(want.distance));
          if (out_result.first_row !== want.first_row)
            report_mismatch("first_row", 32'(out_result.first_row), 32'(want.first_row));
          if (out_result.second_row !== want.second_row)
            report_mismatch("second_row", 32'(out_result.second_row),
                            32'(want.second_row));
          if (out_result.index_error !== want.index_error)
            report_mismatch("index_error", 32'(out_result.index_error),
                            32'(want.index_error));
          checked++;
          if (want.index_error) flagged++;
        end
      end
      if (in_valid && in_ready) begin
        if (in_data.command == pdc_pkg::CMD_LOAD) begin
          store_copy[int'(in_data.row)*ELEMS + int'(in_data.column)] = in_data.element_value;
        end else begin
          distance_queue.push_back(predict_distance(in_data.pair_index));
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          pdc_pkg::REG_NORM_MODE:     norm_q  <= cfg_data[1:0];
          pdc_pkg::REG_ROW_COUNT:     rows_q  <= cfg_data;
          pdc_pkg::REG_ELEMENT_COUNT: elems_q <= cfg_data;
          default: ;
        endcase
      end
      outstanding <= distance_queue.size();
    end
  end

endmodule

>>> dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// drives element loads, pair queries and register settings into the condensed
// pairwise distance block under random idling, stalls and one long hold-off;
// the checker beside the block predicts and compares every result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  localparam int ROWS        = pdc_pkg::DEF_MAX_ROWS;
  localparam int ELEMS       = pdc_pkg::DEF_MAX_ELEMENTS;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE      = 200;
  localparam int HOLD_CYCLES = 400;
  localparam logic [pdc_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  logic                           clk;
  logic                           rst_n;
  logic                           in_valid;
  logic                           in_ready;
  pdc_pkg::in_item_t              in_data;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  pdc_pkg::out_item_t             out_result;
  logic                           cfg_we;
  logic [pdc_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [pdc_pkg::CFG_DATA_W-1:0] cfg_data;

  int   mismatches;
  int   pending;
  int   results_checked;
  int   flagged_results;
  int   idle_pct    = 0;
  int   stall_pct   = 0;
  logic hold_go     = 1'b0;
  logic hold_taken  = 1'b0;
  int   hold_left   = 0;
  int   cycles      = 0;
  int   n_use       = 0;
  int   m_use       = 1;
  int   loads_sent  = 0;
  int   queries_sent = 0;
  bit   loaded [ROWS*ELEMS];

  pairwise_distance_condensed i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_result (out_result),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  pdc_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_result      (out_result),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatches      (mismatches),
    .pending         (pending),
    .results_checked (results_checked),
    .flagged_results (flagged_results)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // result side: random stalls plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_go && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left  <= HOLD_CYCLES;
      out_ready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send(pdc_pkg::in_item_t it);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  function automatic pdc_pkg::in_item_t noise_item();
    pdc_pkg::in_item_t it;
    logic [63:0]       rnd;
    rnd = {$urandom, $urandom};
    it  = rnd[$bits(pdc_pkg::in_item_t)-1:0];
    return it;
  endfunction

  function automatic logic signed [pdc_pkg::VAL_W-1:0] pick_value();
    int          pick;
    int          near;
    logic [31:0] rnd;
    pick = $urandom_range(7);
    near = int'($urandom_range(4)) - 2;
    rnd  = $urandom;
    case (pick)
      0:       pick_value = 16'h8000;
      1:       pick_value = 16'h7fff;
      2, 3:    pick_value = near[pdc_pkg::VAL_W-1:0];
      default: pick_value = rnd[pdc_pkg::VAL_W-1:0];
    endcase
  endfunction

  task automatic load_elem(int r, int c, logic signed [pdc_pkg::VAL_W-1:0] v);
    pdc_pkg::in_item_t it;
    it               = noise_item();
    it.command       = pdc_pkg::CMD_LOAD;
    it.row           = r[pdc_pkg::ROWF_W-1:0];
    it.column        = c[pdc_pkg::ROWF_W-1:0];
    it.element_value = v;
    send(it);
    loaded[r*ELEMS + c] = 1'b1;
    loads_sent++;
  endtask

  task automatic query(int k);
    pdc_pkg::in_item_t it;
    it            = noise_item();
    it.command    = pdc_pkg::CMD_QUERY;
    it.pair_index = k[pdc_pkg::PAIR_W-1:0];
    send(it);
    queries_sent++;
  endtask

  // valid pair, rows filled first so nothing unwritten is read
  task automatic pair_query();
    int i;
    int j;
    int k;
    i = $urandom_range(n_use - 2);
    j = $urandom_range(n_use - 1, i + 1);
    k = i*n_use - i*(i+1)/2 + j - i - 1;
    for (int c = 0; c < m_use; c++) begin
      if (!loaded[i*ELEMS + c]) load_elem(i, c, pick_value());
      if (!loaded[j*ELEMS + c]) load_elem(j, c, pick_value());
    end
    query(k);
  endtask

  task automatic bad_query();
    int npairs;
    npairs = n_use * (n_use - 1) / 2;
    query(int'($urandom_range(2047, npairs)));
  endtask

  task automatic random_load();
    int r;
    int c;
    r = ($urandom_range(3) == 0 || n_use < 2) ? $urandom_range(ROWS - 1)
                                              : $urandom_range(n_use - 1);
    c = ($urandom_range(3) == 0 || m_use < 1) ? $urandom_range(ELEMS - 1)
                                              : $urandom_range(m_use - 1);
    load_elem(r, c, pick_value());
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic reconfigure(logic [1:0] mode, int rows, int elems);
    logic [31:0] rnd;
    rnd = $urandom;
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= pdc_pkg::REG_NORM_MODE;
    cfg_data  <= {rnd[4:0], mode};
    @(posedge clk);
    cfg_index <= pdc_pkg::REG_ROW_COUNT;
    cfg_data  <= rows[pdc_pkg::CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_index <= pdc_pkg::REG_ELEMENT_COUNT;
    cfg_data  <= elems[pdc_pkg::CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_index <= REG_SPARE;
    cfg_data  <= rnd[pdc_pkg::CFG_DATA_W+4:5];
    @(posedge clk);
    cfg_we <= 1'b0;
    n_use = (rows > ROWS) ? ROWS : rows;
    m_use = (elems > ELEMS) ? ELEMS : elems;
  endtask

  task automatic run_phase(logic [1:0] mode, int rows, int elems, int idle, int stall,
                           int actions, bit squeeze);
    int sel;
    reconfigure(mode, rows, elems);
    idle_pct = idle;
    stall_pct <= stall;
    if (squeeze) begin
      hold_go <= 1'b1;
      repeat (4) pair_query();
    end
    repeat (actions) begin
      sel = $urandom_range(99);
      if (sel < 35) random_load();
      else if (sel < 88 && n_use >= 2) pair_query();
      else bad_query();
    end
  endtask

  initial begin
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: no rows in use, every pair is out of range
    query(0);
    query(2047);

    // extreme values, opposite signs in one column
    reconfigure(pdc_pkg::NORM_L1, 3, 2);
    load_elem(0, 0, 16'h8000);
    load_elem(0, 1, 16'h0000);
    load_elem(1, 0, 16'h7fff);
    load_elem(1, 1, 16'h0000);
    load_elem(2, 0, 16'h7fff);
    load_elem(2, 1, 16'hffff);
    for (int k = 0; k < 4; k++) query(k);
    reconfigure(pdc_pkg::NORM_COUNT, 3, 2);
    for (int k = 0; k < 3; k++) query(k);
    reconfigure(pdc_pkg::NORM_MAX, 3, 2);
    query(1);
    reconfigure(pdc_pkg::NORM_L2, 3, 2);
    query(1);

    run_phase(pdc_pkg::NORM_COUNT,   5,   4,  0,  0, 30, 1'b0);
    run_phase(pdc_pkg::NORM_L1,     64,   1, 50,  0, 30, 1'b0);
    run_phase(pdc_pkg::NORM_L2,      8,   4,  0, 50, 30, 1'b0);
    run_phase(pdc_pkg::NORM_MAX,     2,  16, 25, 25, 20, 1'b0);
    run_phase(pdc_pkg::NORM_L2,    127,   1,  0,  0, 30, 1'b0);
    run_phase(pdc_pkg::NORM_L1,      2, 127, 50,  0, 20, 1'b0);
    run_phase(pdc_pkg::NORM_COUNT,   1,   6,  0, 50, 15, 1'b0);
    run_phase(pdc_pkg::NORM_MAX,    20,   0, 25, 25, 20, 1'b0);
    run_phase(pdc_pkg::NORM_L2,     12,   6,  0,  0, 30, 1'b1);
    run_phase(pdc_pkg::NORM_MAX,    64,   2, 50, 50, 30, 1'b0);
    settle();

    $display("%0d element loads and %0d pair queries sent, %0d results checked,",
             loads_sent, queries_sent, results_checked);
    $display("%0d out of range; four norms, count extremes, idle, stalls, long hold-off",
             flagged_results);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/pdc_pkg.sv
rtl/pdc_store.sv
rtl/pdc_isqrt.sv
rtl/pdc_core.sv
rtl/pairwise_distance_condensed.sv
dv/pdc_checker.sv
dv/testbench.sv
